>>> rtl/bpc_pkg.sv
// Shared types, constants and field helpers for the button press classifier.
// No dependencies; every other rtl file refers to it by scoped names.
package bpc_pkg;

    // Binding table size and field widths
    localparam int BINDINGS   = 4;
    localparam int BINDING_W  = 9;
    localparam int PIN_W      = 6;
    localparam int COUNT_W    = 3;
    localparam int MS_W       = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Reset values of the timing registers
    localparam logic [MS_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [MS_W-1:0] LONG_PRESS_RESET = 16'd500;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BINDING_0     = 3'd0,
        REG_BINDING_1     = 3'd1,
        REG_BINDING_2     = 3'd2,
        REG_BINDING_3     = 3'd3,
        REG_BINDING_COUNT = 3'd4,
        REG_DEBOUNCE      = 3'd5,
        REG_LONG_PRESS    = 3'd6,
        REG_UNUSED        = 3'd7
    } cfg_reg_t;

    // Request kinds on the input channel
    typedef enum logic {
        REQ_EDGE = 1'b0,
        REQ_POLL = 1'b1
    } req_t;

    // Action codes held in a binding
    typedef enum logic [1:0] {
        ACT_NEXT  = 2'd0,
        ACT_PREV  = 2'd1,
        ACT_PRESS = 2'd2,
        ACT_CLOSE = 2'd3
    } action_t;

    // Encoder step codes, 2-bit two's complement
    localparam logic [1:0] STEP_NONE  = 2'b00;
    localparam logic [1:0] STEP_PLUS  = 2'b01;
    localparam logic [1:0] STEP_MINUS = 2'b11;

    // Configuration register file contents
    typedef struct packed {
        logic [BINDINGS-1:0][BINDING_W-1:0] binding;
        logic [COUNT_W-1:0]                 binding_count;
        logic [MS_W-1:0]                    debounce_ms;
        logic [MS_W-1:0]                    long_press_ms;
    } cfg_t;

    // Command broadcast to every binding slice
    typedef struct packed {
        logic              edge_en;
        logic              poll;
        logic              pressed;
        logic [PIN_W-1:0]  pin;
        logic [TIME_W-1:0] now;
    } cmd_t;

    // Binding word fields
    function automatic logic [PIN_W-1:0] bind_pin(input logic [BINDING_W-1:0] b);
        return b[5:0];
    endfunction

    function automatic logic bind_long(input logic [BINDING_W-1:0] b);
        return b[6];
    endfunction

    function automatic action_t bind_action(input logic [BINDING_W-1:0] b);
        return action_t'(b[8:7]);
    endfunction

endpackage

>>> rtl/button_press_classifier.sv
// Button press classifier: debounced short/long press detection per binding.
// A poll word waits in the input register for a free result register.
// One word per cycle while no poll waits; edge words produce no result word.
// Reset (rst_n low, asynchronous): registers to defaults, all binding state
// and triggers cleared, no result pending. No clearing pass is needed.
module button_press_classifier
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             req_type,
    input  logic [bpc_pkg::PIN_W-1:0]        pin_number,
    input  logic                             is_pressed,
    input  logic [bpc_pkg::TIME_W-1:0]       now_ms,
    // Result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [1:0]                encoder_step,
    output logic                             select_pressed,
    output logic                             close_app
);

    bpc_pkg::cfg_t cfg;

    // Input register
    logic                           s1_valid_reg;
    logic                           s1_type_reg;
    logic [bpc_pkg::PIN_W-1:0]      s1_pin_reg;
    logic                           s1_pressed_reg;
    logic [bpc_pkg::TIME_W-1:0]     s1_now_reg;

    // Result register
    logic                           out_valid_reg;
    logic [1:0]                     step_reg;
    logic                           sel_reg;
    logic                           close_reg;

    logic                           out_free;
    logic                           s1_advance;
    bpc_pkg::cmd_t                  cmd;
    logic [bpc_pkg::COUNT_W-1:0]    count_sat;
    logic [bpc_pkg::BINDINGS-1:0]   active;
    logic [bpc_pkg::BINDINGS-1:0]   fire;
    logic [1:0]                     step_next;
    logic                           sel_next;
    logic                           close_next;

    bpc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Handshake: an edge always drains, a poll waits for a free result slot
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg
                        && ((bpc_pkg::req_t'(s1_type_reg) == bpc_pkg::REQ_EDGE) || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_type_reg    <= req_type;
            s1_pin_reg     <= pin_number;
            s1_pressed_reg <= is_pressed;
            s1_now_reg     <= now_ms;
        end
    end

    // Command to the binding slices
    always_comb
    begin
        cmd.edge_en = s1_valid_reg
                      && (bpc_pkg::req_t'(s1_type_reg) == bpc_pkg::REQ_EDGE);
        cmd.poll    = s1_valid_reg
                      && (bpc_pkg::req_t'(s1_type_reg) == bpc_pkg::REQ_POLL) && out_free;
        cmd.pressed = s1_pressed_reg;
        cmd.pin     = s1_pin_reg;
        cmd.now     = s1_now_reg;
    end

    // Active bindings: count saturates at the table size
    assign count_sat = (cfg.binding_count > bpc_pkg::COUNT_W'(bpc_pkg::BINDINGS))
                       ? bpc_pkg::COUNT_W'(bpc_pkg::BINDINGS) : cfg.binding_count;

    for (genvar gi = 0; gi < bpc_pkg::BINDINGS; gi++)
    begin : g_binding
        assign active[gi] = (count_sat > bpc_pkg::COUNT_W'(gi));

        bpc_binding u_binding
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .binding_word  (cfg.binding[gi]),
            .active        (active[gi]),
            .debounce_ms   (cfg.debounce_ms),
            .long_press_ms (cfg.long_press_ms),
            .cmd           (cmd),
            .fire          (fire[gi])
        );
    end

    // Merge fired actions; later bindings override the encoder step
    always_comb
    begin
        step_next  = bpc_pkg::STEP_NONE;
        sel_next   = 1'b0;
        close_next = 1'b0;
        for (int i = 0; i < bpc_pkg::BINDINGS; i++)
        begin
            if (fire[i])
            begin
                unique case (bpc_pkg::bind_action(cfg.binding[i]))
                    bpc_pkg::ACT_NEXT:  step_next  = bpc_pkg::STEP_PLUS;
                    bpc_pkg::ACT_PREV:  step_next  = bpc_pkg::STEP_MINUS;
                    bpc_pkg::ACT_PRESS: sel_next   = 1'b1;
                    bpc_pkg::ACT_CLOSE: close_next = 1'b1;
                    default:            ;
                endcase
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.poll)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.poll)
        begin
            step_reg  <= step_next;
            sel_reg   <= sel_next;
            close_reg <= close_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign encoder_step   = signed'(step_reg);
    assign select_pressed = sel_reg;
    assign close_app      = close_reg;

endmodule

>>> rtl/bpc_cfg.sv
// Configuration register file: binding table, active count and timing values.
// Depends on bpc_pkg.
module bpc_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output bpc_pkg::cfg_t                    cfg
);

    bpc_pkg::cfg_t cfg_reg;

    // Register writes, masked to each register's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.binding       <= '0;
            cfg_reg.binding_count <= '0;
            cfg_reg.debounce_ms   <= bpc_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ms <= bpc_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (bpc_pkg::cfg_reg_t'(cfg_index))
                bpc_pkg::REG_BINDING_0:
                    cfg_reg.binding[0] <= cfg_wdata[bpc_pkg::BINDING_W-1:0];
                bpc_pkg::REG_BINDING_1:
                    cfg_reg.binding[1] <= cfg_wdata[bpc_pkg::BINDING_W-1:0];
                bpc_pkg::REG_BINDING_2:
                    cfg_reg.binding[2] <= cfg_wdata[bpc_pkg::BINDING_W-1:0];
                bpc_pkg::REG_BINDING_3:
                    cfg_reg.binding[3] <= cfg_wdata[bpc_pkg::BINDING_W-1:0];
                bpc_pkg::REG_BINDING_COUNT:
                    cfg_reg.binding_count <= cfg_wdata[bpc_pkg::COUNT_W-1:0];
                bpc_pkg::REG_DEBOUNCE:
                    cfg_reg.debounce_ms <= cfg_wdata[bpc_pkg::MS_W-1:0];
                bpc_pkg::REG_LONG_PRESS:
                    cfg_reg.long_press_ms <= cfg_wdata[bpc_pkg::MS_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/bpc_binding.sv
// One binding slice: debounce, press timing and short/long trigger flags.
// Depends on bpc_pkg.
module bpc_binding
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [bpc_pkg::BINDING_W-1:0]    binding_word,
    input  logic                             active,
    input  logic [bpc_pkg::MS_W-1:0]         debounce_ms,
    input  logic [bpc_pkg::MS_W-1:0]         long_press_ms,
    input  bpc_pkg::cmd_t                    cmd,
    output logic                             fire
);

    logic [bpc_pkg::TIME_W-1:0] last_change_reg;
    logic [bpc_pkg::TIME_W-1:0] press_start_reg;
    logic                       held_reg;
    logic                       short_reg;
    logic                       long_reg;

    logic [bpc_pkg::TIME_W-1:0] since_change;
    logic [bpc_pkg::TIME_W-1:0] held_time;
    logic                       hit;
    logic                       take;
    logic                       is_long_press;

    // Edge qualification: pin match plus debounce window (wrapping difference)
    assign since_change  = cmd.now - last_change_reg;
    assign held_time     = cmd.now - press_start_reg;
    assign hit           = cmd.edge_en && active
                           && (bpc_pkg::bind_pin(binding_word) == cmd.pin);
    assign take          = hit && (since_change >= {16'd0, debounce_ms});
    assign is_long_press = (held_time >= {16'd0, long_press_ms});

    // Trigger selected by the binding's event kind
    assign fire = active
                  && (bpc_pkg::bind_long(binding_word) ? long_reg : short_reg);

    // Per-binding state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_change_reg <= '0;
            press_start_reg <= '0;
            held_reg        <= 1'b0;
            short_reg       <= 1'b0;
            long_reg        <= 1'b0;
        end
        else if (cmd.poll)
        begin
            short_reg <= 1'b0;
            long_reg  <= 1'b0;
        end
        else if (take)
        begin
            last_change_reg <= cmd.now;
            if (cmd.pressed)
            begin
                press_start_reg <= cmd.now;
                held_reg        <= 1'b1;
            end
            else if (held_reg)
            begin
                held_reg <= 1'b0;
                if (is_long_press)
                    long_reg <= 1'b1;
                else
                    short_reg <= 1'b1;
            end
        end
    end

endmodule

>>> rtl/bpc_checker.sv
// Port-level checks for the button press classifier, bound to the top level.
// Depends on bpc_pkg and button_press_classifier.
module bpc_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             req_type,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic signed [1:0]                encoder_step,
    input  logic                             select_pressed,
    input  logic                             close_app
);

    // No result word is pending while in reset
    a_no_out_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result word valid during reset");

    // A stalled result word holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(encoder_step)
            && $stable(select_pressed) && $stable(close_app))
        else $error("stalled result word changed");

    // Encoder step is -1, 0 or +1 only
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> encoder_step != 2'sb10)
        else $error("encoder step out of range");

    // A new result word follows an accepted poll word
    a_out_from_poll: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready
            && (req_type == bpc_pkg::REQ_POLL), 2))
        else $error("result word without a poll");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .encoder_step   (encoder_step),
    .select_pressed (select_pressed),
    .close_app      (close_app)
);
